// ----- rtl/core/csc_smv_pkg.sv -----
`timescale 1ns / 1ps

package csc_smv_pkg;

    localparam int IDX_W     = 10;
    localparam int X_W       = 32;
    localparam int Y_W       = 48;
    localparam int CFG_W     = 11;
    localparam int PROD_W    = 2 * X_W;
    localparam int FRAC_W    = 16;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    localparam logic [CFG_W-1:0] NUM_ROWS_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_ACCUM  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic x_wr;
        logic rd_x;
        logic rd_y;
        logic mul_en;
        logic add_en;
        logic y_wr_sum;
        logic clr_init;
        logic clr_wr;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic row_ok;
        logic col_ok;
        logic clr_empty;
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/core/csc_smv_ram.sv -----
`timescale 1ns / 1ps

module csc_smv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/csc_smv_dp.sv -----
`timescale 1ns / 1ps

module csc_smv_dp #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  csc_smv_pkg::op_t                        in_op,
    input  logic [csc_smv_pkg::IDX_W-1:0]           in_row,
    input  logic [csc_smv_pkg::IDX_W-1:0]           in_col,
    input  logic signed [csc_smv_pkg::X_W-1:0]      in_value,
    input  logic                                    cfg_valid,
    input  logic [csc_smv_pkg::CFG_W-1:0]           cfg_data,
    input  csc_smv_pkg::dp_cmd_t                    cmd,
    output csc_smv_pkg::dp_stat_t                   stat,
    input  logic                                    m_tready,
    output logic                                    m_tvalid,
    output logic signed [csc_smv_pkg::Y_W-1:0]      y_value,
    output logic [csc_smv_pkg::IDX_W-1:0]           y_row
);

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW  = ($clog2(MAX_ROWS + 1) > csc_smv_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : csc_smv_pkg::CFG_W;
    localparam int YW  = csc_smv_pkg::Y_W;

    // latched word
    csc_smv_pkg::op_t                     op_reg;
    logic [csc_smv_pkg::IDX_W-1:0]        row_reg;
    logic [csc_smv_pkg::IDX_W-1:0]        col_reg;
    logic signed [csc_smv_pkg::X_W-1:0]   value_reg;

    logic [csc_smv_pkg::CFG_W-1:0]        num_rows_reg;
    logic [LW-1:0]                        clr_cnt_reg;
    logic [LW-1:0]                        clr_lim_reg;
    logic [LW-1:0]                        clr_lim_next;

    logic signed [csc_smv_pkg::PROD_W-1:0] prod_reg;
    logic signed [csc_smv_pkg::PROD_W-1:0] prod_next;
    logic signed [YW-1:0]                  y_hold_reg;
    logic signed [YW-1:0]                  sum_reg;
    logic signed [YW-1:0]                  sum_next;
    logic signed [YW-1:0]                  inc;
    logic signed [YW:0]                    sum_wide;

    logic                                  out_valid_reg;
    logic signed [YW-1:0]                  y_value_reg;
    logic [csc_smv_pkg::IDX_W-1:0]         y_row_reg;

    logic [csc_smv_pkg::X_W-1:0]           x_rdata;
    logic [YW-1:0]                         y_rdata;
    logic                                  y_we;
    logic [RAW-1:0]                        y_waddr;
    logic [YW-1:0]                         y_wdata;
    logic                                  row_ok;
    logic                                  col_ok;

    assign row_ok = (32'(row_reg) < 32'(MAX_ROWS));
    assign col_ok = (32'(col_reg) < 32'(MAX_COLS));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            row_reg   <= in_row;
            col_reg   <= in_col;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= csc_smv_pkg::NUM_ROWS_RST;
        end else if (cfg_valid) begin
            num_rows_reg <= cfg_data;
        end
    end

    // clear sweep; reset starts a full pass
    always_comb begin
        if (LW'(num_rows_reg) > LW'(MAX_ROWS)) begin
            clr_lim_next = LW'(MAX_ROWS);
        end else begin
            clr_lim_next = LW'(num_rows_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            clr_lim_reg <= LW'(MAX_ROWS);
        end else if (cmd.clr_init) begin
            clr_cnt_reg <= '0;
            clr_lim_reg <= clr_lim_next;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + LW'(1);
        end
    end

    // product, floor to Q32.16, saturating add
    assign prod_next = value_reg * $signed(x_rdata);
    assign inc       = prod_reg[csc_smv_pkg::PROD_W-1:csc_smv_pkg::FRAC_W];
    assign sum_wide  = {y_hold_reg[YW-1], y_hold_reg} + {inc[YW-1], inc};

    always_comb begin
        if (sum_wide[YW] != sum_wide[YW-1]) begin
            sum_next = sum_wide[YW] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
        end else begin
            sum_next = sum_wide[YW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg   <= prod_next;
            y_hold_reg <= $signed(y_rdata);
        end
        if (cmd.add_en) begin
            sum_reg <= sum_next;
        end
    end

    csc_smv_ram #(
        .WIDTH (csc_smv_pkg::X_W),
        .DEPTH (MAX_COLS)
    ) u_x_ram (
        .aclk  (aclk),
        .we    (cmd.x_wr),
        .waddr (CAW'(col_reg)),
        .wdata (value_reg),
        .re    (cmd.rd_x),
        .raddr (CAW'(col_reg)),
        .rdata (x_rdata)
    );

    assign y_we    = cmd.y_wr_sum | cmd.clr_wr;
    assign y_waddr = cmd.clr_wr ? clr_cnt_reg[RAW-1:0] : RAW'(row_reg);
    assign y_wdata = cmd.clr_wr ? '0 : sum_reg;

    csc_smv_ram #(
        .WIDTH (YW),
        .DEPTH (MAX_ROWS)
    ) u_y_ram (
        .aclk  (aclk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (cmd.rd_y),
        .raddr (RAW'(row_reg)),
        .rdata (y_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            y_value_reg <= row_ok ? $signed(y_rdata) : '0;
            y_row_reg   <= row_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign y_value  = y_value_reg;
    assign y_row    = y_row_reg;

    assign stat.op        = op_reg;
    assign stat.row_ok    = row_ok;
    assign stat.col_ok    = col_ok;
    assign stat.clr_empty = (clr_lim_reg == '0);
    assign stat.clr_last  = (clr_cnt_reg == clr_lim_reg - LW'(1));
    assign stat.out_busy  = out_valid_reg & ~m_tready;

    a_y_one_writer : assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_wr && cmd.y_wr_sum))
        else $error("y RAM written by clear and accumulate at once");

    a_clr_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> (clr_cnt_reg < clr_lim_reg))
        else $error("clear sweep past its limit");

    a_mul_after_read : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> $past(cmd.rd_x && cmd.rd_y))
        else $error("multiply without preceding RAM reads");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=>
            (out_valid_reg && $stable(y_row_reg) && $stable(y_value_reg)))
        else $error("result overwritten");

endmodule

// ----- rtl/core/csc_smv_ctrl.sv -----
`timescale 1ns / 1ps

module csc_smv_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  csc_smv_pkg::dp_stat_t stat,
    output csc_smv_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_ADD  = 7'b0001000,
        ST_WB   = 7'b0010000,
        ST_CLR  = 7'b0100000,
        ST_RESP = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // reset enters the clear sweep so y starts at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.op)
                    csc_smv_pkg::OP_LOAD_X: begin
                        cmd.x_wr   = stat.col_ok;
                        state_next = ST_IDLE;
                    end
                    csc_smv_pkg::OP_ACCUM: begin
                        if (stat.row_ok && stat.col_ok) begin
                            cmd.rd_x   = 1'b1;
                            cmd.rd_y   = 1'b1;
                            state_next = ST_MUL;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    csc_smv_pkg::OP_CLEAR: begin
                        cmd.clr_init = 1'b1;
                        state_next   = ST_CLR;
                    end
                    csc_smv_pkg::OP_READ: begin
                        cmd.rd_y   = stat.row_ok;
                        state_next = ST_RESP;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_en = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.y_wr_sum = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_CLR: begin
                if (stat.clr_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.clr_wr = 1'b1;
                    if (stat.clr_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed next cycle");

    a_load_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded over a pending result");

    a_state_onehot : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

// ----- rtl/core/csc_sparse_matvec_accumulator.sv -----
`timescale 1ns / 1ps

// Sparse matrix-vector accumulator, y = A*x, with A streamed column by column.
// Each input word carries a command in s_tuser: load an x entry, accumulate
// one nonzero (y[row] += value * x[col], Q16.16 times Q16.16, floored to
// Q32.16, saturated to 48 bits), clear the first num_rows entries of y, or
// read one y entry (the only command that returns a word on m_). One word is
// worked on at a time by a state machine over two simple dual-port RAMs: load
// writes an x entry; accumulate does a RAM read, registered 32x32 multiply,
// saturating add and write back; read waits while an earlier result is
// pending; clear zeroes n = min(num_rows, MAX_ROWS) y entries, one per cycle.
// After reset the block runs a clearing pass over all MAX_ROWS y entries
// before s_tready first rises; cfg writes are taken at any time but must only
// be issued while the block is idle. x entries read before being loaded
// return undefined data. A finished read waits in an output register, so
// the next word is accepted while m_tvalid is still pending.
module csc_sparse_matvec_accumulator #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csc_smv_pkg::S_TDATA_W-1:0]    s_tdata,  // row_index[9:0], col_index[19:10],
                                                           // value[51:20], zero pad [55:52]
    input  logic [1:0]                           s_tuser,  // command[1:0]
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csc_smv_pkg::M_TDATA_W-1:0]    m_tdata,  // y_value[47:0], y_row[57:48],
                                                           // zero pad [63:58]
    // num_rows register
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csc_smv_pkg::CFG_W-1:0]        cfg_data
);

    csc_smv_pkg::dp_cmd_t                   cmd;
    csc_smv_pkg::dp_stat_t                  stat;
    logic signed [csc_smv_pkg::Y_W-1:0]     y_value;
    logic [csc_smv_pkg::IDX_W-1:0]          y_row;

    // register write is always taken
    assign cfg_ready = 1'b1;

    csc_smv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csc_smv_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (csc_smv_pkg::op_t'(s_tuser)),
        .in_row    (s_tdata[9:0]),
        .in_col    (s_tdata[19:10]),
        .in_value  ($signed(s_tdata[51:20])),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .y_value   (y_value),
        .y_row     (y_row)
    );

    assign m_tdata = {6'd0, y_row, y_value};

endmodule
